// File: rtl/bpbc_pkg.sv
// bpbc_pkg: shared types, constants and bit functions for the cbc bit-permutation cipher
// used by bpbc_ctrl, bpbc_dp and bit_permutation_block_cipher_cbc
// no dependencies
package bpbc_pkg;

  localparam int ROUND_COUNT_DEF = 4;
  localparam int WORD_W          = 32;
  localparam int IDX_W           = 5;
  localparam int TBL_COUNT       = 4;
  localparam int PERM_DEPTH      = 128;
  localparam int SWAP_COUNT      = 768;
  localparam int PM_STEPS        = 62;
  localparam int RK_STEPS        = 18;
  localparam int PADDR_W         = 6;
  localparam int CNT_W           = 10;

  // register indexes, paddr[5:3]
  localparam logic [2:0] REG_KEY_HIGH = 3'd0;
  localparam logic [2:0] REG_KEY_LOW  = 3'd1;
  localparam logic [2:0] REG_IV_HIGH  = 3'd2;
  localparam logic [2:0] REG_IV_LOW   = 3'd3;
  localparam logic [2:0] REG_MODE     = 3'd4;

  typedef enum logic {
    CMD_KEY   = 1'b0,
    CMD_BLOCK = 1'b1
  } cmd_code_t;

  typedef struct packed {
    logic        command;
    logic        first_block;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_RK,
    ST_SH_RD,
    ST_SH_WA,
    ST_SH_WB,
    ST_PM_RD,
    ST_PM_AP,
    ST_RND,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load_key;
    logic             load_block;
    logic             init_wr;
    logic             rk_step;
    logic             sh_rd;
    logic             sh_wa;
    logic             sh_wb;
    logic             pm_rd;
    logic             pm_ap;
    logic             round_en;
    logic             finish;
    logic [CNT_W-1:0] cnt;
    logic [1:0]       tbl;
    logic [1:0]       rnd;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic decrypt;
  } sts_t;

  // bit m of every index k, the identity mapping as bit planes
  function automatic logic [WORD_W-1:0] ident_plane(input int m);
    logic [WORD_W-1:0] p;
    for (int k = 0; k < WORD_W; k++) begin
      p[k] = ((k >> m) & 1) != 0;
    end
    return p;
  endfunction

  // swap bits a and b of w
  function automatic logic [WORD_W-1:0] xchg(input logic [WORD_W-1:0] w,
                                            input logic [IDX_W-1:0] a,
                                            input logic [IDX_W-1:0] b);
    logic d;
    logic [WORD_W-1:0] m;
    d = w[a] ^ w[b];
    m = ({{(WORD_W-1){1'b0}}, d} << a) | ({{(WORD_W-1){1'b0}}, d} << b);
    return w ^ m;
  endfunction

  // out bit k takes w bit given by the planes at column k
  function automatic logic [WORD_W-1:0] gather(input logic [WORD_W-1:0] w,
                                              input logic [IDX_W-1:0][WORD_W-1:0] p);
    logic [WORD_W-1:0] o;
    logic [IDX_W-1:0] s;
    for (int k = 0; k < WORD_W; k++) begin
      s = {p[4][k], p[3][k], p[2][k], p[1][k], p[0][k]};
      o[k] = w[s];
    end
    return o;
  endfunction

endpackage

// File: rtl/bpbc_ram.sv
// bpbc_ram: generic ram, one write port and two registered read ports
// no dependencies
module bpbc_ram #(
  parameter int WIDTH = 5,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/bpbc_ctrl.sv
// bpbc_ctrl: sequencer for key setup and block rounds, owns the output valid flag
// depends on bpbc_pkg
module bpbc_ctrl #(
  parameter int ROUND_COUNT = bpbc_pkg::ROUND_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           in_command,
  output logic           out_valid,
  input  logic           out_ready,
  input  bpbc_pkg::sts_t sts,
  output bpbc_pkg::cmd_t cmd
);

  localparam logic [bpbc_pkg::CNT_W-1:0] LAST_INIT = bpbc_pkg::CNT_W'(bpbc_pkg::PERM_DEPTH - 1);
  localparam logic [bpbc_pkg::CNT_W-1:0] LAST_RK   = bpbc_pkg::CNT_W'(bpbc_pkg::RK_STEPS - 1);
  localparam logic [bpbc_pkg::CNT_W-1:0] LAST_SW   = bpbc_pkg::CNT_W'(bpbc_pkg::SWAP_COUNT - 1);
  localparam logic [bpbc_pkg::CNT_W-1:0] LAST_PM   = bpbc_pkg::CNT_W'(bpbc_pkg::PM_STEPS - 1);
  localparam logic [bpbc_pkg::CNT_W-1:0] LAST_RND  = bpbc_pkg::CNT_W'(ROUND_COUNT - 1);

  bpbc_pkg::state_t state, state_next;
  logic [bpbc_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [1:0] tbl, tbl_next;
  logic out_valid_next;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= bpbc_pkg::ST_IDLE;
      cnt       <= '0;
      tbl       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      tbl       <= tbl_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    tbl_next       = tbl;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.cnt        = cnt;
    cmd.tbl        = tbl;
    cmd.rnd        = sts.decrypt ? (2'(ROUND_COUNT - 1) - cnt[1:0]) : cnt[1:0];
    unique case (state)
      bpbc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cnt_next = '0;
        tbl_next = '0;
        if (in_valid) begin
          if (in_command == bpbc_pkg::CMD_KEY) begin
            cmd.load_key = 1'b1;
            state_next   = bpbc_pkg::ST_INIT;
          end else begin
            cmd.load_block = 1'b1;
            state_next     = bpbc_pkg::ST_RND;
          end
        end
      end
      bpbc_pkg::ST_INIT: begin
        cmd.init_wr = 1'b1;
        if (cnt == LAST_INIT) begin
          cnt_next   = '0;
          state_next = bpbc_pkg::ST_RK;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bpbc_pkg::ST_RK: begin
        cmd.rk_step = 1'b1;
        if (cnt == LAST_RK) begin
          cnt_next   = '0;
          state_next = bpbc_pkg::ST_SH_RD;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bpbc_pkg::ST_SH_RD: begin
        cmd.sh_rd  = 1'b1;
        state_next = bpbc_pkg::ST_SH_WA;
      end
      bpbc_pkg::ST_SH_WA: begin
        cmd.sh_wa  = 1'b1;
        state_next = bpbc_pkg::ST_SH_WB;
      end
      bpbc_pkg::ST_SH_WB: begin
        cmd.sh_wb  = 1'b1;
        state_next = bpbc_pkg::ST_SH_RD;
        if (cnt == LAST_SW) begin
          cnt_next = '0;
          tbl_next = tbl + 1'b1;
          if (tbl == 2'd3) begin
            state_next = bpbc_pkg::ST_PM_RD;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bpbc_pkg::ST_PM_RD: begin
        cmd.pm_rd  = 1'b1;
        state_next = bpbc_pkg::ST_PM_AP;
      end
      bpbc_pkg::ST_PM_AP: begin
        cmd.pm_ap  = 1'b1;
        state_next = bpbc_pkg::ST_PM_RD;
        if (cnt == LAST_PM) begin
          cnt_next = '0;
          tbl_next = tbl + 1'b1;
          if (tbl == 2'd3) begin
            state_next = bpbc_pkg::ST_IDLE;
          end
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bpbc_pkg::ST_RND: begin
        cmd.round_en = 1'b1;
        if (cnt == LAST_RND) begin
          cnt_next   = '0;
          state_next = bpbc_pkg::ST_DONE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      bpbc_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish     = 1'b1;
          out_valid_next = 1'b1;
          state_next     = bpbc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bpbc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/bpbc_dp.sv
// bpbc_dp: config registers, key schedule, permutation planes, round logic, chaining
// depends on bpbc_pkg and bpbc_ram
module bpbc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  bpbc_pkg::cmd_t                  cmd,
  output bpbc_pkg::sts_t                  sts,
  input  bpbc_pkg::in_item_t              in_item,
  output bpbc_pkg::out_item_t             out_item,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bpbc_pkg::PADDR_W-1:0]    paddr,
  input  logic [63:0]                     pwdata,
  output logic [63:0]                     prdata
);

  localparam int AW = $clog2(bpbc_pkg::PERM_DEPTH);

  logic [63:0] key_high, key_low, iv_high, iv_low;
  logic        decrypt_mode;

  logic [15:0][7:0] sbytes;
  logic [15:0][31:0] rk;
  logic [31:0] diff_word, acc, hsum;
  logic [3:0][4:0][31:0] pfw, pinv;
  logic [4:0] j, jn;

  logic [3:0][31:0] blk;
  logic [63:0] cv_high, cv_low, cin_high, cin_low;
  logic        mode_q;

  logic             ram_we, ram_re;
  logic [AW-1:0]    waddr, raddr_a, raddr_b;
  logic [4:0]       wdata, rd_a, rd_b;
  logic             pm_fwd;
  logic [4:0]       pm_i, pm_o;

  logic [3:0][31:0] enc, dec, sub;
  logic [63:0]      c_high, c_low;
  logic [63:0]      x_high, x_low;

  assign sts.decrypt = mode_q;

  // config register reads
  always_comb begin
    unique case (paddr[5:3])
      bpbc_pkg::REG_KEY_HIGH: prdata = key_high;
      bpbc_pkg::REG_KEY_LOW:  prdata = key_low;
      bpbc_pkg::REG_IV_HIGH:  prdata = iv_high;
      bpbc_pkg::REG_IV_LOW:   prdata = iv_low;
      bpbc_pkg::REG_MODE:     prdata = {63'd0, decrypt_mode};
      default:                prdata = '0;
    endcase
  end

  // permutation table ram addressing
  assign jn     = j + sbytes[0][4:0];
  assign pm_fwd = cmd.cnt < bpbc_pkg::CNT_W'(31);
  assign pm_i   = pm_fwd ? cmd.cnt[4:0] : 5'(7'd62 - cmd.cnt[6:0]);
  assign pm_o   = pm_fwd ? (pm_i + 5'd1) : (pm_i - 5'd1);

  always_comb begin
    ram_we  = cmd.init_wr || cmd.sh_wa || cmd.sh_wb;
    ram_re  = cmd.sh_rd || cmd.pm_rd;
    waddr   = cmd.cnt[AW-1:0];
    wdata   = cmd.cnt[4:0];
    raddr_a = {cmd.tbl, pm_i};
    raddr_b = {cmd.tbl, pm_o};
    if (cmd.sh_rd) begin
      raddr_a = {cmd.tbl, cmd.cnt[4:0]};
      raddr_b = {cmd.tbl, jn};
    end
    if (cmd.sh_wa) begin
      waddr = {cmd.tbl, cmd.cnt[4:0]};
      wdata = rd_b;
    end else if (cmd.sh_wb) begin
      waddr = {cmd.tbl, j};
      wdata = rd_a;
    end
  end

  bpbc_ram #(
    .WIDTH(bpbc_pkg::IDX_W),
    .DEPTH(bpbc_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (ram_re),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rd_a),
    .rdata_b(rd_b)
  );

  // schedule running sum
  assign hsum = rk[0] + rk[1] + rk[2] + rk[3] + acc;

  // chaining value for this block
  assign c_high = in_item.first_block ? iv_high : cv_high;
  assign c_low  = in_item.first_block ? iv_low  : cv_low;

  // block entering the rounds, chaining folded in first when encrypting
  assign x_high = decrypt_mode ? in_item.block_high : (in_item.block_high ^ c_high);
  assign x_low  = decrypt_mode ? in_item.block_low  : (in_item.block_low ^ c_low);

  // one encryption and one decryption round
  always_comb begin
    enc[0] = bpbc_pkg::gather(blk[0], pfw[0]) ^ blk[3] ^ rk[{cmd.rnd, 2'd0}];
    enc[1] = bpbc_pkg::gather(blk[1], pfw[1]) ^ enc[0] ^ rk[{cmd.rnd, 2'd1}];
    enc[2] = bpbc_pkg::gather(blk[2], pfw[2]) ^ enc[1] ^ rk[{cmd.rnd, 2'd2}];
    enc[3] = bpbc_pkg::gather(blk[3], pfw[3]) ^ enc[2] ^ rk[{cmd.rnd, 2'd3}];
    for (int g = 0; g < 4; g++) begin
      sub[g] = blk[g] - diff_word;
    end
    dec[3] = bpbc_pkg::gather(sub[3] ^ rk[{cmd.rnd, 2'd3}] ^ sub[2], pinv[3]);
    dec[2] = bpbc_pkg::gather(sub[2] ^ rk[{cmd.rnd, 2'd2}] ^ sub[1], pinv[2]);
    dec[1] = bpbc_pkg::gather(sub[1] ^ rk[{cmd.rnd, 2'd1}] ^ sub[0], pinv[1]);
    dec[0] = bpbc_pkg::gather(sub[0] ^ rk[{cmd.rnd, 2'd0}] ^ dec[3], pinv[0]);
  end

  // state with reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      key_high     <= '0;
      key_low      <= '0;
      iv_high      <= '0;
      iv_low       <= '0;
      decrypt_mode <= 1'b0;
      rk           <= '0;
      diff_word    <= '0;
      cv_high      <= '0;
      cv_low       <= '0;
      mode_q       <= 1'b0;
      for (int t = 0; t < 4; t++) begin
        for (int m = 0; m < 5; m++) begin
          pfw[t][m]  <= bpbc_pkg::ident_plane(m);
          pinv[t][m] <= bpbc_pkg::ident_plane(m);
        end
      end
    end else begin
      // config writes
      if (psel && penable && pwrite) begin
        unique case (paddr[5:3])
          bpbc_pkg::REG_KEY_HIGH: key_high <= pwdata;
          bpbc_pkg::REG_KEY_LOW:  key_low <= pwdata;
          bpbc_pkg::REG_IV_HIGH:  iv_high <= pwdata;
          bpbc_pkg::REG_IV_LOW:   iv_low <= pwdata;
          bpbc_pkg::REG_MODE:     decrypt_mode <= pwdata[0];
          default: ;
        endcase
      end
      // key setup start: first round words from the key, identity planes
      if (cmd.load_key) begin
        rk[0] <= key_high[63:32];
        rk[1] <= key_high[31:0];
        rk[2] <= key_low[63:32];
        rk[3] <= key_low[31:0];
        for (int t = 0; t < 4; t++) begin
          for (int m = 0; m < 5; m++) begin
            pfw[t][m]  <= bpbc_pkg::ident_plane(m);
            pinv[t][m] <= bpbc_pkg::ident_plane(m);
          end
        end
      end
      // round word schedule
      if (cmd.rk_step) begin
        if (cmd.cnt == bpbc_pkg::CNT_W'(bpbc_pkg::RK_STEPS - 1)) begin
          diff_word <= hsum;
        end else if (cmd.cnt != '0) begin
          rk[4'(cmd.cnt[4:0] - 5'd1)] <= hsum;
        end
      end
      // fold one swap into the forward or inverse planes
      if (cmd.pm_ap) begin
        for (int m = 0; m < 5; m++) begin
          if (pm_fwd) begin
            pfw[cmd.tbl][m] <= bpbc_pkg::xchg(pfw[cmd.tbl][m], rd_a, rd_b);
          end else begin
            pinv[cmd.tbl][m] <= bpbc_pkg::xchg(pinv[cmd.tbl][m], rd_a, rd_b);
          end
        end
      end
      // block start
      if (cmd.load_block) begin
        mode_q  <= decrypt_mode;
        cv_high <= c_high;
        cv_low  <= c_low;
      end
      // block end: chaining update
      if (cmd.finish) begin
        if (mode_q) begin
          cv_high <= cin_high;
          cv_low  <= cin_low;
        end else begin
          cv_high <= {blk[0], blk[1]};
          cv_low  <= {blk[2], blk[3]};
        end
      end
    end
  end

  // working registers without reset
  always_ff @(posedge clk) begin
    if (cmd.load_key) begin
      acc <= 32'h0000_0001;
      j   <= '0;
      for (int i = 0; i < 8; i++) begin
        sbytes[i]     <= key_high[63 - 8*i -: 8];
        sbytes[8 + i] <= key_low[63 - 8*i -: 8];
      end
    end
    if (cmd.rk_step) begin
      acc <= hsum;
    end
    // key byte update, then rotate so the next byte sits at the front
    if (cmd.sh_rd) begin
      j <= jn;
      for (int i = 0; i < 15; i++) begin
        sbytes[i] <= sbytes[i + 1];
      end
      sbytes[15] <= sbytes[0] + sbytes[1];
    end
    // word g of the block sits in blk[g]
    if (cmd.load_block) begin
      cin_high <= in_item.block_high;
      cin_low  <= in_item.block_low;
      blk      <= {x_low[31:0], x_low[63:32], x_high[31:0], x_high[63:32]};
    end
    if (cmd.round_en) begin
      for (int g = 0; g < 4; g++) begin
        blk[g] <= mode_q ? dec[g] : (enc[g] + diff_word);
      end
    end
    if (cmd.finish) begin
      if (mode_q) begin
        out_item.result_high <= {blk[0], blk[1]} ^ cv_high;
        out_item.result_low  <= {blk[2], blk[3]} ^ cv_low;
      end else begin
        out_item.result_high <= {blk[0], blk[1]};
        out_item.result_low  <= {blk[2], blk[3]};
      end
    end
  end

endmodule

// File: rtl/bit_permutation_block_cipher_cbc.sv
// bit_permutation_block_cipher_cbc: top level, 128-bit bit-permutation cipher in cbc mode
// depends on bpbc_pkg, bpbc_ctrl, bpbc_dp, bpbc_ram
//
// Usage: write key_high/key_low (byte addresses 0, 8), iv_high/iv_low (16, 24) and
// decrypt_mode (32) over the apb port while the block is idle. Then send items on the
// in channel: command 0 runs the key setup from the key registers and gives no result;
// command 1 processes one block and gives one result item on the out channel.
// first_block 1 reloads the chaining value from the iv registers before the block.
// Key setup runs after acceptance: the table fill, the round word schedule, the swaps
// for each table, each swap a read and two writes on the single write port of the
// permutation table ram, then the planes built in read and apply steps. A block runs
// its rounds, then loads the output register; one round is done per cycle by the round
// logic. in_ready is high only while idle.
// A result waits in the output register while out_ready is low; the next item is still
// accepted and runs its rounds, then holds until the output register frees.
// Reset (rst, synchronous) clears the registers, zeroes the round words, diffusion word
// and chaining value and sets identity permutations; blocks before any key setup use
// that schedule.
module bit_permutation_block_cipher_cbc #(
  parameter int ROUND_COUNT = bpbc_pkg::ROUND_COUNT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  bpbc_pkg::in_item_t           in_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output bpbc_pkg::out_item_t          out_item,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bpbc_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                  pwdata,
  output logic [63:0]                  prdata,
  output logic                         pready
);

  bpbc_pkg::cmd_t cmd;
  bpbc_pkg::sts_t sts;

  assign pready = 1'b1;

  bpbc_ctrl #(
    .ROUND_COUNT(ROUND_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_command(in_item.command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bpbc_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .sts     (sts),
    .in_item (in_item),
    .out_item(out_item),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata)
  );

  // busy after any accepted item
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready right after accepting an item");

  // a result only appears after a finished block
  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.finish))
    else $error("output valid without a finished block");

  // at most one datapath action per cycle
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load_key, cmd.load_block, cmd.init_wr, cmd.rk_step, cmd.sh_rd,
              cmd.sh_wa, cmd.sh_wb, cmd.pm_rd, cmd.pm_ap, cmd.round_en, cmd.finish}))
    else $error("more than one datapath action");

endmodule
